// ===== hw/rtl/dllm_pkg.sv =====
// ----------------------------------------------------------------------------
// dllm_pkg
// Shared types and constants for the doubly linked list manager: request and
// result items, link words, the decoded command and the queue sizes.
// ----------------------------------------------------------------------------
package dllm_pkg;

  localparam int NODE_SLOTS = 256;
  localparam int LIST_COUNT = 4;
  localparam int SLOT_W     = $clog2(NODE_SLOTS);
  localparam int LIST_W     = $clog2(LIST_COUNT);
  localparam int COUNT_W    = $clog2(NODE_SLOTS + 1);
  localparam int LINK_W     = SLOT_W + 1;

  // command queue and result queue depth (power of two)
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REQ_APPEND     = 2'd0,
    REQ_INS_AFTER  = 2'd1,
    REQ_INS_BEFORE = 2'd2,
    REQ_REMOVE     = 2'd3
  } req_t;

  typedef struct packed {
    req_t       req_type;
    logic [1:0] list_id;
    logic [7:0] ref_node;
    logic [7:0] new_node;
  } request_t;

  typedef struct packed {
    logic [7:0] head_slot;
    logic [7:0] tail_slot;
    logic       list_empty;
    logic [8:0] element_count;
  } result_t;

  // link word: null flag beside the slot index
  typedef struct packed {
    logic              nul;
    logic [SLOT_W-1:0] slot;
  } link_t;

  localparam link_t LINK_NULL = '{nul: 1'b1, slot: '0};

  // decoded request handed from the front end to the execute side
  typedef struct packed {
    req_t              op;
    logic [LIST_W-1:0] list;
    logic [SLOT_W-1:0] ref_slot;
    logic [SLOT_W-1:0] new_slot;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WR1  = 3'b010,
    ST_WR2  = 3'b100
  } back_state_t;

  function automatic link_t to_link(input logic [SLOT_W-1:0] s);
    link_t l;
    l.nul  = 1'b0;
    l.slot = s;
    return l;
  endfunction

endpackage

// ===== hw/rtl/dllm_ram.sv =====
// ----------------------------------------------------------------------------
// dllm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dllm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/dllm_front.sv =====
// ----------------------------------------------------------------------------
// dllm_front
// Request front end: takes request transfers, decodes them into commands and
// buffers them in a short queue for the execute side.
// ----------------------------------------------------------------------------
module dllm_front import dllm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  request_t request,
  output logic     full,
  output logic     cmd_valid,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  cmd_t              q [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;
  logic              push_ok;
  cmd_t              decoded;

  assign push_ok   = push && !full;
  assign full      = (count == (QPTR_W+1)'(QDEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = q[rptr];

  always_comb begin
    decoded.op       = request.req_type;
    decoded.list     = request.list_id[LIST_W-1:0];
    decoded.ref_slot = request.ref_node[SLOT_W-1:0];
    decoded.new_slot = request.new_node[SLOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push_ok) begin
        wptr <= wptr + 1'b1;
      end
      if (cmd_take) begin
        rptr <= rptr + 1'b1;
      end
      case ({push_ok, cmd_take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wptr] <= decoded;
    end
  end

endmodule

// ===== hw/rtl/dllm_back.sv =====
// ----------------------------------------------------------------------------
// dllm_back
// Execute side: reads the reference node's links, writes the link tables in
// two ordered write steps, WR1 then WR2, updates head, tail and count of the
// list and queues the result.
// ----------------------------------------------------------------------------
module dllm_back import dllm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_take,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  back_state_t       state;
  cmd_t              cur;
  link_t             nx_q;
  link_t             pv_q;
  link_t             head_q [LIST_COUNT];
  link_t             tail_q [LIST_COUNT];
  logic [COUNT_W-1:0] cnt_q [LIST_COUNT];

  result_t           oq [QDEPTH];
  logic [QPTR_W-1:0] owptr;
  logic [QPTR_W-1:0] orptr;
  logic [QPTR_W:0]   ocount;
  logic              opush;
  logic              opop;

  logic              nx_we, pv_we;
  logic [SLOT_W-1:0] nx_waddr, pv_waddr;
  link_t             nx_wdata, pv_wdata;
  logic [LINK_W-1:0] nx_rraw, pv_rraw;
  link_t             nx_rd, pv_rd, nx, pv;

  link_t             h, t, new_h, new_t;
  logic [COUNT_W-1:0] c, new_c;
  result_t           res_next;
  logic [SLOT_W-1:0] r, n;

  dllm_ram #(.WIDTH(LINK_W), .DEPTH(NODE_SLOTS)) u_next_ram (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (cmd.ref_slot),
    .rdata (nx_rraw)
  );

  dllm_ram #(.WIDTH(LINK_W), .DEPTH(NODE_SLOTS)) u_prev_ram (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (cmd.ref_slot),
    .rdata (pv_rraw)
  );

  assign nx_rd = link_t'(nx_rraw);
  assign pv_rd = link_t'(pv_rraw);
  // read data is live in WR1, held copy afterwards
  assign nx = (state == ST_WR1) ? nx_rd : nx_q;
  assign pv = (state == ST_WR1) ? pv_rd : pv_q;

  assign cmd_take = (state == ST_IDLE) && cmd_valid && (ocount != (QPTR_W+1)'(QDEPTH));
  assign opush    = (state == ST_WR2);
  assign opop     = pop && !empty;
  assign empty    = (ocount == '0);
  assign result   = oq[orptr];

  assign r = cur.ref_slot;
  assign n = cur.new_slot;
  assign h = head_q[cur.list];
  assign t = tail_q[cur.list];
  assign c = cnt_q[cur.list];

  // link table writes, in the order the operation defines them
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = n;
    nx_wdata = LINK_NULL;
    pv_we    = 1'b0;
    pv_waddr = n;
    pv_wdata = LINK_NULL;
    case (state)
      ST_WR1: begin
        case (cur.op)
          REQ_APPEND: begin
            nx_we    = 1'b1;
            pv_we    = 1'b1;
            pv_wdata = h.nul ? LINK_NULL : t;
          end
          REQ_INS_AFTER: begin
            pv_we    = 1'b1;
            pv_wdata = to_link(r);
            nx_we    = 1'b1;
            nx_wdata = nx;
          end
          REQ_INS_BEFORE: begin
            nx_we    = 1'b1;
            nx_wdata = to_link(r);
            pv_we    = 1'b1;
            pv_wdata = pv;
          end
          REQ_REMOVE: begin
            nx_we    = !pv.nul;
            nx_waddr = pv.slot;
            nx_wdata = nx;
            pv_we    = !nx.nul;
            pv_waddr = nx.slot;
            pv_wdata = pv;
          end
          default: ;
        endcase
      end
      ST_WR2: begin
        case (cur.op)
          REQ_APPEND: begin
            nx_we    = !h.nul;
            nx_waddr = t.slot;
            nx_wdata = to_link(n);
          end
          REQ_INS_AFTER: begin
            pv_we    = !nx.nul;
            pv_waddr = nx.slot;
            pv_wdata = to_link(n);
            nx_we    = 1'b1;
            nx_waddr = r;
            nx_wdata = to_link(n);
          end
          REQ_INS_BEFORE: begin
            nx_we    = !pv.nul;
            nx_waddr = pv.slot;
            nx_wdata = to_link(n);
            pv_we    = 1'b1;
            pv_waddr = r;
            pv_wdata = to_link(n);
          end
          REQ_REMOVE: begin
            nx_we    = 1'b1;
            nx_waddr = r;
            pv_we    = 1'b1;
            pv_waddr = r;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // list registers after the operation
  always_comb begin
    new_h = h;
    new_t = t;
    case (cur.op)
      REQ_APPEND: begin
        if (h.nul) begin
          new_h = to_link(n);
        end
        new_t = to_link(n);
      end
      REQ_INS_AFTER: begin
        if (nx.nul) begin
          new_t = to_link(n);
        end
      end
      REQ_INS_BEFORE: begin
        if (pv.nul) begin
          new_h = to_link(n);
        end
      end
      REQ_REMOVE: begin
        if (pv.nul) begin
          new_h = nx;
        end
        if (nx.nul) begin
          new_t = pv;
        end
      end
      default: ;
    endcase

    new_c = c;
    if (cur.op == REQ_REMOVE) begin
      if (c != '0) begin
        new_c = c - COUNT_W'(1);
      end
    end else if (c != COUNT_W'(NODE_SLOTS)) begin
      new_c = c + COUNT_W'(1);
    end

    res_next.list_empty    = new_h.nul;
    res_next.head_slot     = new_h.nul ? 8'd0 : 8'(new_h.slot);
    res_next.tail_slot     = (new_t.nul || new_h.nul) ? 8'd0 : 8'(new_t.slot);
    res_next.element_count = 9'(new_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      owptr  <= '0;
      orptr  <= '0;
      ocount <= '0;
      for (int i = 0; i < LIST_COUNT; i++) begin
        head_q[i] <= LINK_NULL;
        tail_q[i] <= LINK_NULL;
        cnt_q[i]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_take) begin
            state <= ST_WR1;
          end
        end
        ST_WR1: begin
          state <= ST_WR2;
        end
        ST_WR2: begin
          state             <= ST_IDLE;
          head_q[cur.list]  <= new_h;
          tail_q[cur.list]  <= new_t;
          cnt_q[cur.list]   <= new_c;
        end
        default: state <= ST_IDLE;
      endcase
      if (opush) begin
        owptr <= owptr + 1'b1;
      end
      if (opop) begin
        orptr <= orptr + 1'b1;
      end
      case ({opush, opop})
        2'b10:   ocount <= ocount + 1'b1;
        2'b01:   ocount <= ocount - 1'b1;
        default: ocount <= ocount;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cur <= cmd;
    end
    if (state == ST_WR1) begin
      nx_q <= nx_rd;
      pv_q <= pv_rd;
    end
    if (opush) begin
      oq[owptr] <= res_next;
    end
  end

endmodule

// ===== hw/rtl/doubly_linked_list_manager_core.sv =====
// Path: command queue, then execute states WR1 and WR2; the result is queued in WR2.
// Flow: a new command is taken only once the last is through (link read, then two ordered
// write steps on the link tables, one write port each) and the result queue has room.
// Reset: synchronous; all lists empty with zero count, both queues empty. Link tables are
// not cleared and hold nothing meaningful until written.
// ----------------------------------------------------------------------------
// doubly_linked_list_manager_core
// Several doubly linked lists over a shared pool of node slots; append,
// insert after, insert before and remove, reporting head, tail and count.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager_core import dllm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  request_t request,
  output logic     full,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  dllm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .request   (request),
    .full      (full),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  dllm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // an accepted request is always visible to the execute side next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> cmd_valid)
    else $error("accepted request lost in command queue");

  // no new command is taken while the execute sequence (WR1, WR2) runs
  a_take_spacing: assert property (@(posedge clk) disable iff (rst)
    cmd_take |=> !cmd_take ##1 !cmd_take)
    else $error("command taken while execute side busy");

  // every taken command yields a queued result
  a_result_queued: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> ##3 !empty)
    else $error("no result queued after command");

  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    full |-> cmd_valid)
    else $error("command queue full but nothing offered");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for doubly_linked_list_manager_core. Requests are pushed
// through the input queue interface while a local predictor keeps its own link
// tables and list registers. Every result popped from the output queue is
// compared against the oldest predicted one. Stimulus is a directed pass, a
// long run of well-formed list traffic, a count ceiling run, then misuse.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dllm_pkg::*;

  logic     clk;
  logic     rst     = 1'b1;
  logic     push    = 1'b0;
  logic     pop     = 1'b0;
  request_t request = '0;
  logic     full;
  logic     empty;
  result_t  result;

  doubly_linked_list_manager_core uut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .request (request),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  link_t      next_tbl [NODE_SLOTS];
  link_t      prev_tbl [NODE_SLOTS];
  bit         next_set [NODE_SLOTS];
  bit         prev_set [NODE_SLOTS];
  link_t      head_lnk [LIST_COUNT];
  link_t      tail_lnk [LIST_COUNT];
  logic [8:0] node_cnt [LIST_COUNT];

  // list membership as the well-formed traffic intends it, -1 for a free slot
  int         owner [NODE_SLOTS];

  result_t    pending_results [$];
  int         errors;
  int         checked;
  int         peak_count;
  int         empty_seen;
  int         op_tally [4];
  bit         calm;
  bit         hold_ask;

  function automatic void set_next(input logic [7:0] s, input link_t l);
    next_tbl[s] = l;
    next_set[s] = 1'b1;
  endfunction

  function automatic void set_prev(input logic [7:0] s, input link_t l);
    prev_tbl[s] = l;
    prev_set[s] = 1'b1;
  endfunction

  // each step sees the links as the earlier steps of the same request left them
  function automatic result_t apply_request(input request_t rq);
    logic [1:0] li;
    logic [7:0] r;
    logic [7:0] n;
    link_t      rl;
    link_t      nl;
    link_t      t;
    result_t    rs;
    li = rq.list_id;
    r  = rq.ref_node;
    n  = rq.new_node;
    rl = '{nul: 1'b0, slot: r};
    nl = '{nul: 1'b0, slot: n};
    case (rq.req_type)
      REQ_APPEND: begin
        set_next(n, LINK_NULL);
        set_prev(n, LINK_NULL);
        if (head_lnk[li].nul) begin
          head_lnk[li] = nl;
        end else begin
          set_prev(n, tail_lnk[li]);
          set_next(tail_lnk[li].slot, nl);
        end
        tail_lnk[li] = nl;
      end
      REQ_INS_AFTER: begin
        set_prev(n, rl);
        t = next_tbl[r];
        if (t.nul) begin
          set_next(n, LINK_NULL);
          tail_lnk[li] = nl;
        end else begin
          set_next(n, t);
          set_prev(t.slot, nl);
        end
        set_next(r, nl);
      end
      REQ_INS_BEFORE: begin
        set_next(n, rl);
        t = prev_tbl[r];
        if (t.nul) begin
          set_prev(n, LINK_NULL);
          head_lnk[li] = nl;
        end else begin
          set_prev(n, t);
          set_next(t.slot, nl);
        end
        set_prev(r, nl);
      end
      REQ_REMOVE: begin
        t = prev_tbl[r];
        if (t.nul) begin
          head_lnk[li] = next_tbl[r];
        end else begin
          set_next(t.slot, next_tbl[r]);
        end
        t = next_tbl[r];
        if (t.nul) begin
          tail_lnk[li] = prev_tbl[r];
        end else begin
          set_prev(t.slot, prev_tbl[r]);
        end
        set_next(r, LINK_NULL);
        set_prev(r, LINK_NULL);
      end
    endcase
    // count saturates at both ends
    if (rq.req_type == REQ_REMOVE) begin
      if (node_cnt[li] != 9'd0) node_cnt[li] = node_cnt[li] - 9'd1;
    end else if (node_cnt[li] < NODE_SLOTS) begin
      node_cnt[li] = node_cnt[li] + 9'd1;
    end
    rs.list_empty    = head_lnk[li].nul;
    rs.head_slot     = rs.list_empty ? 8'd0 : head_lnk[li].slot;
    rs.tail_slot     = (rs.list_empty || tail_lnk[li].nul) ? 8'd0 : tail_lnk[li].slot;
    rs.element_count = node_cnt[li];
    return rs;
  endfunction

  function automatic void note_owner(input request_t rq);
    if (rq.req_type == REQ_REMOVE) begin
      if (owner[rq.ref_node] == int'(rq.list_id)) owner[rq.ref_node] = -1;
    end else begin
      owner[rq.new_node] = int'(rq.list_id);
    end
  endfunction

  function automatic int pick_slot(input int who);
    int found [$];
    for (int s = 0; s < NODE_SLOTS; s++) begin
      if (owner[s] == who) found.push_back(s);
    end
    if (found.size() == 0) return -1;
    return found[$urandom_range(0, found.size() - 1)];
  endfunction

  function automatic request_t mk_req(input req_t op, input logic [1:0] li,
                                      input logic [7:0] r, input logic [7:0] n);
    request_t rq;
    rq.req_type = op;
    rq.list_id  = li;
    rq.ref_node = r;
    rq.new_node = n;
    return rq;
  endfunction

  function automatic void cmp_field(input string name, input logic [8:0] want,
                                    input logic [8:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // push stays high across back-to-back transfers; dropped only for an idle gap
  task automatic send_request(input request_t rq);
    while (!calm && $urandom_range(0, 99) < 35) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    request <= rq;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_results.push_back(apply_request(rq));
    op_tally[rq.req_type]++;
  endtask

  task automatic test_directed();
    request_t seq [$];
    seq = {
      mk_req(REQ_APPEND,     2'd0, 8'd255, 8'd0),    // first node of an empty list
      mk_req(REQ_APPEND,     2'd0, 8'd0,   8'd255),
      mk_req(REQ_INS_AFTER,  2'd0, 8'd255, 8'd17),   // after the tail
      mk_req(REQ_INS_AFTER,  2'd0, 8'd0,   8'd85),   // mid-list
      mk_req(REQ_INS_BEFORE, 2'd0, 8'd0,   8'd170),  // before the head
      mk_req(REQ_INS_BEFORE, 2'd0, 8'd17,  8'd1),    // mid-list
      mk_req(REQ_APPEND,     2'd3, 8'd12,  8'd254),
      mk_req(REQ_INS_BEFORE, 2'd3, 8'd254, 8'd128),
      mk_req(REQ_APPEND,     2'd1, 8'd99,  8'd127),
      mk_req(REQ_APPEND,     2'd2, 8'd255, 8'd2),
      mk_req(REQ_REMOVE,     2'd3, 8'd128, 8'd255),  // head
      mk_req(REQ_REMOVE,     2'd3, 8'd254, 8'd0),    // last node, list goes empty
      mk_req(REQ_REMOVE,     2'd3, 8'd254, 8'd77),   // empty list, count holds at zero
      mk_req(REQ_REMOVE,     2'd0, 8'd17,  8'd3),    // tail
      mk_req(REQ_REMOVE,     2'd0, 8'd85,  8'd200),  // mid-list
      mk_req(REQ_REMOVE,     2'd0, 8'd170, 8'd9),    // head
      mk_req(REQ_REMOVE,     2'd1, 8'd127, 8'd127),  // only node
      mk_req(REQ_APPEND,     2'd1, 8'd44,  8'd127),  // slot reuse
      mk_req(REQ_INS_AFTER,  2'd2, 8'd2,   8'd3),
      mk_req(REQ_INS_BEFORE, 2'd2, 8'd2,   8'd252)
    };
    foreach (seq[i]) begin
      send_request(seq[i]);
      note_owner(seq[i]);
    end
  endtask

  // well-formed traffic: lists alternately grow and shrink in blocks of 200
  task automatic test_random_lists(input int n_items);
    request_t rq;
    int       li;
    int       mem;
    int       fr;
    int       rm_pct;
    int       pick;
    for (int k = 0; k < n_items; k++) begin
      calm = (k >= 450 && k < 650);
      if (k % 350 == 100) hold_ask = 1'b1;
      rm_pct = ((k / 200) % 2 == 0) ? 30 : 70;
      fr = pick_slot(-1);
      do begin
        li  = $urandom_range(0, LIST_COUNT - 1);
        mem = pick_slot(li);
      end while (mem < 0 && fr < 0);
      rq.list_id  = 2'(li);
      rq.ref_node = 8'($urandom);
      rq.new_node = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (mem >= 0 && (fr < 0 || pick < rm_pct)) begin
        rq.req_type = REQ_REMOVE;
        rq.ref_node = 8'(mem);
      end else begin
        rq.new_node = 8'(fr);
        if (mem < 0 || pick < rm_pct + (100 - rm_pct) / 3) begin
          rq.req_type = REQ_APPEND;
        end else begin
          rq.ref_node = 8'(mem);
          rq.req_type = pick[0] ? REQ_INS_AFTER : REQ_INS_BEFORE;
        end
      end
      send_request(rq);
      note_owner(rq);
    end
    calm = 1'b0;
  endtask

  // enough appends on one list to pin its count at the pool size
  task automatic test_count_ceiling(input int n_items);
    request_t rq;
    for (int k = 0; k < n_items; k++) begin
      rq.req_type = REQ_APPEND;
      rq.list_id  = 2'(LIST_COUNT - 1);
      rq.ref_node = 8'($urandom);
      rq.new_node = 8'($urandom);
      send_request(rq);
    end
  endtask

  // arbitrary requests; the reference slot always has both links written
  task automatic test_misuse(input int n_items);
    request_t rq;
    for (int k = 0; k < n_items; k++) begin
      rq.req_type = req_t'($urandom_range(0, 3));
      rq.list_id  = 2'($urandom);
      rq.new_node = 8'($urandom);
      do begin
        rq.ref_node = 8'($urandom);
      end while (!(next_set[rq.ref_node] && prev_set[rq.ref_node]));
      send_request(rq);
    end
  endtask

  initial begin : result_drain
    int      hold_left;
    result_t want;
    hold_left = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: head %0d tail %0d empty %0b count %0d",
                   $time, result.head_slot, result.tail_slot, result.list_empty,
                   result.element_count);
        end else begin
          want = pending_results.pop_front();
          checked++;
          cmp_field("head_slot", 9'(want.head_slot), 9'(result.head_slot));
          cmp_field("tail_slot", 9'(want.tail_slot), 9'(result.tail_slot));
          cmp_field("list_empty", 9'(want.list_empty), 9'(result.list_empty));
          cmp_field("element_count", want.element_count, result.element_count);
          if (int'(want.element_count) > peak_count) peak_count = int'(want.element_count);
          if (want.list_empty) empty_seen++;
        end
      end
      // long hold-off lets the block fill and push back on the sender
      if (hold_ask) begin
        hold_ask  = 1'b0;
        hold_left = $urandom_range(60, 120);
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (calm || $urandom_range(0, 99) >= 35);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("doubly_linked_list_manager_core test failed");
    $finish;
  end

  initial begin : stimulus
    errors     = 0;
    checked    = 0;
    peak_count = 0;
    empty_seen = 0;
    calm       = 1'b0;
    hold_ask   = 1'b0;
    foreach (op_tally[i]) op_tally[i] = 0;
    for (int s = 0; s < NODE_SLOTS; s++) begin
      owner[s]    = -1;
      next_set[s] = 1'b0;
      prev_set[s] = 1'b0;
    end
    for (int l = 0; l < LIST_COUNT; l++) begin
      head_lnk[l] = LINK_NULL;
      tail_lnk[l] = LINK_NULL;
      node_cnt[l] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_lists(1100);
    test_count_ceiling(262);
    test_misuse(270);

    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Covered %0d appends, %0d inserts after, %0d inserts before, %0d removes;",
             op_tally[REQ_APPEND], op_tally[REQ_INS_AFTER], op_tally[REQ_INS_BEFORE],
             op_tally[REQ_REMOVE]);
    $display("%0d results compared, %0d of them on an empty list, largest count %0d.",
             checked, empty_seen, peak_count);
    if (errors == 0) begin
      $display("doubly_linked_list_manager_core test passed");
    end else begin
      $display("doubly_linked_list_manager_core test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dllm_pkg.sv
hw/rtl/dllm_ram.sv
hw/rtl/dllm_front.sv
hw/rtl/dllm_back.sv
hw/rtl/doubly_linked_list_manager_core.sv
test/tb_top.sv
